### rtl/asfc_pkg.sv
// ----------------------------------------------------------------------------
// asfc_pkg: alarm / snooze / sleep fade controller package
// Item types, mode and LED command codes, register indexes and time constants.
// ----------------------------------------------------------------------------
package asfc_pkg;

  localparam int MODE_W      = 3;
  localparam int CMD_W       = 3;
  localparam int PAT_W       = 8;
  localparam int SEC_W       = 32;
  localparam int SOD_W       = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int HOUR_W      = 5;
  localparam int MIN_W       = 6;
  localparam int SNOOZE_W    = 8;
  localparam int DELAY_W     = 11;
  localparam int FADE_MIN_W  = 11;
  localparam int STEPS_W     = 8;
  localparam int SNZ_SEC_W   = 14;
  localparam int DLY_SEC_W   = 17;
  localparam int STEP_LEN_W  = 17;

  localparam logic [SOD_W-1:0]   SECS_PER_DAY  = 17'd86400;
  localparam logic [SOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
  localparam logic [SOD_W-1:0]   SECS_PER_MIN  = 17'd60;

  localparam logic [MODE_W-1:0] MODE_INIT       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CONFIG     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WAIT       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SNOOZE     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RUN        = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SLEEPSTART = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SLEEPDELAY = 3'd6;
  localparam logic [MODE_W-1:0] MODE_FADE       = 3'd7;

  localparam logic [CMD_W-1:0] LED_NONE       = 3'd0;
  localparam logic [CMD_W-1:0] LED_RING       = 3'd1;
  localparam logic [CMD_W-1:0] LED_FILL_BLACK = 3'd2;
  localparam logic [CMD_W-1:0] LED_FADE_START = 3'd3;
  localparam logic [CMD_W-1:0] LED_FADE_STEP  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_ALARM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_HOUR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_MINUTE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SNOOZE_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_PATTERN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_MIN      = 3'd6;

  typedef struct packed {
    logic [SEC_W-1:0] now_seconds;
    logic [SOD_W-1:0] local_second_of_day;
    logic             reconfig_event;
    logic             snooze_event;
    logic             stop_event;
    logic             manual_start_event;
    logic             sleep_start_event;
    logic             sleep_stop_event;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CMD_W-1:0]  led_command;
    logic [PAT_W-1:0]  led_pattern;
    logic              status_ok_pulse;
  } out_item_t;

endpackage

### rtl/alarm_snooze_sleep_fade_controller.sv
// ----------------------------------------------------------------------------
// alarm_snooze_sleep_fade_controller: alarm clock mode controller
// One wake-up in, one mode / LED command result out, with snooze timing,
// alarm crossing detection and a stepped sleep fade.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register until its result is registered on out_data.
// Throughput: one item per cycle while out_ready is high; the mode update is a
// single pass between the input register and the result register.
// The fade step length is computed by a constant multiply when fade_minutes is written.
// Reset (rst_n low, synchronous) clears all but the item data registers, mode to init.
module alarm_snooze_sleep_fade_controller #(
  parameter int FADE_STEPS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  asfc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output asfc_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [asfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import asfc_pkg::*;

  // floor(fade_minutes * 60 / FADE_STEPS) by reciprocal multiply, exact for 11-bit input
  localparam int    STEP_SHIFT = FADE_MIN_W + $clog2(FADE_STEPS);
  localparam longint STEP_MULT = (longint'(60) * (longint'(1) << STEP_SHIFT)
                                  + longint'(FADE_STEPS) - 1) / longint'(FADE_STEPS);
  localparam int    MULT_W     = $clog2(STEP_MULT + 1);
  localparam int    PROD_W     = FADE_MIN_W + MULT_W;

  // configuration
  logic                  enable_alarm_r;
  logic [HOUR_W-1:0]     wake_hour_r;
  logic [MIN_W-1:0]      wake_minute_r;
  logic [SNOOZE_W-1:0]   snooze_min_r;
  logic [PAT_W-1:0]      ring_pattern_r;
  logic [DELAY_W-1:0]    sleep_delay_r;
  logic [STEP_LEN_W-1:0] step_len_r;
  logic [PROD_W-1:0]     step_prod;

  // pipeline
  logic                  s1_valid_r;
  in_item_t              s1_item_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;
  out_item_t             out_item_nxt;
  logic                  adv;

  // state
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [SEC_W-1:0]      last_sec_r, last_sec_nxt;
  logic [SOD_W-1:0]      last_sod_r, last_sod_nxt;
  logic [SEC_W-1:0]      snooze_began_r, snooze_began_nxt;
  logic [SEC_W-1:0]      sleep_mark_r, sleep_mark_nxt;
  logic [STEPS_W-1:0]    steps_done_r, steps_done_nxt;

  // datapath
  logic [SOD_W-1:0]      target_raw, target, prev;
  logic [SOD_W:0]        dist_raw;
  logic [SOD_W-1:0]      wake_dist;
  logic [SEC_W-1:0]      elapsed, snooze_el, sleep_el;
  logic [SNZ_SEC_W-1:0]  snooze_len;
  logic [DLY_SEC_W-1:0]  delay_len;
  logic                  crossed;

  assign cfg_ready = 1'b1;
  assign step_prod = PROD_W'(cfg_data[FADE_MIN_W-1:0]) * PROD_W'(STEP_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_alarm_r <= 1'b0;
      wake_hour_r    <= '0;
      wake_minute_r  <= '0;
      snooze_min_r   <= '0;
      ring_pattern_r <= '0;
      sleep_delay_r  <= '0;
      step_len_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE_ALARM: enable_alarm_r <= cfg_data[0];
        CFG_WAKE_HOUR:    wake_hour_r    <= cfg_data[HOUR_W-1:0];
        CFG_WAKE_MINUTE:  wake_minute_r  <= cfg_data[MIN_W-1:0];
        CFG_SNOOZE_MIN:   snooze_min_r   <= cfg_data[SNOOZE_W-1:0];
        CFG_RING_PATTERN: ring_pattern_r <= cfg_data[PAT_W-1:0];
        CFG_SLEEP_DELAY:  sleep_delay_r  <= cfg_data[DELAY_W-1:0];
        CFG_FADE_MIN:     step_len_r     <= STEP_LEN_W'(step_prod >> STEP_SHIFT);
        default: ;
      endcase
    end
  end

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // alarm crossing, all distances modulo one day
  assign target_raw = SOD_W'(wake_hour_r * SECS_PER_HOUR)
                    + SOD_W'(wake_minute_r * SECS_PER_MIN);
  assign target     = (target_raw >= SECS_PER_DAY) ? target_raw - SECS_PER_DAY : target_raw;
  assign prev       = (last_sod_r >= SECS_PER_DAY) ? last_sod_r - SECS_PER_DAY : last_sod_r;
  assign dist_raw   = {1'b0, target} + {1'b0, SECS_PER_DAY} - {1'b0, prev};
  assign wake_dist  = (dist_raw >= {1'b0, SECS_PER_DAY})
                    ? SOD_W'(dist_raw - {1'b0, SECS_PER_DAY}) : SOD_W'(dist_raw);
  assign elapsed    = s1_item_r.now_seconds - last_sec_r;
  assign crossed    = SEC_W'(wake_dist) <= elapsed;

  assign snooze_el  = s1_item_r.now_seconds - snooze_began_r;
  assign sleep_el   = s1_item_r.now_seconds - sleep_mark_r;
  assign snooze_len = SNZ_SEC_W'(snooze_min_r * SNZ_SEC_W'(SECS_PER_MIN));
  assign delay_len  = DLY_SEC_W'(sleep_delay_r * SECS_PER_MIN);

  always_comb begin
    mode_nxt         = mode_r;
    last_sec_nxt     = last_sec_r;
    last_sod_nxt     = last_sod_r;
    snooze_began_nxt = snooze_began_r;
    sleep_mark_nxt   = sleep_mark_r;
    steps_done_nxt   = steps_done_r;
    out_item_nxt     = '0;

    case (mode_r)
      MODE_INIT: begin
        if (s1_item_r.reconfig_event) mode_nxt = MODE_CONFIG;
      end
      MODE_CONFIG: mode_nxt = MODE_WAIT;
      MODE_WAIT: begin
        if (s1_item_r.reconfig_event) mode_nxt = MODE_CONFIG;
        else if (s1_item_r.sleep_start_event) mode_nxt = MODE_SLEEPSTART;
        else if (enable_alarm_r && (s1_item_r.manual_start_event || crossed))
          mode_nxt = MODE_RUN;
      end
      MODE_SNOOZE: begin
        if (s1_item_r.stop_event) mode_nxt = MODE_WAIT;
        else if (s1_item_r.reconfig_event) mode_nxt = MODE_CONFIG;
        else if (snooze_el > SEC_W'(snooze_len)) mode_nxt = MODE_RUN;
      end
      MODE_RUN: begin
        if (s1_item_r.stop_event) mode_nxt = MODE_WAIT;
        else if (s1_item_r.reconfig_event) mode_nxt = MODE_CONFIG;
        else if (s1_item_r.snooze_event) mode_nxt = MODE_SNOOZE;
      end
      MODE_SLEEPSTART: mode_nxt = MODE_SLEEPDELAY;
      MODE_SLEEPDELAY: begin
        if (s1_item_r.sleep_stop_event) mode_nxt = MODE_WAIT;
        else if (s1_item_r.reconfig_event) mode_nxt = MODE_CONFIG;
        else if (sleep_el > SEC_W'(delay_len)) mode_nxt = MODE_FADE;
      end
      default: begin
        if (s1_item_r.sleep_stop_event || steps_done_r > STEPS_W'(FADE_STEPS))
          mode_nxt = MODE_WAIT;
        else if (s1_item_r.reconfig_event) mode_nxt = MODE_CONFIG;
      end
    endcase

    case (mode_r)
      MODE_INIT: begin
        out_item_nxt.status_ok_pulse = (mode_nxt != mode_r);
      end
      MODE_CONFIG, MODE_WAIT, MODE_SNOOZE: begin
        last_sec_nxt = s1_item_r.now_seconds;
        last_sod_nxt = s1_item_r.local_second_of_day;
      end
      MODE_RUN: begin
        last_sec_nxt = s1_item_r.now_seconds;
        last_sod_nxt = s1_item_r.local_second_of_day;
        if (s1_item_r.snooze_event) begin
          snooze_began_nxt         = s1_item_r.now_seconds;
          out_item_nxt.led_command = LED_FILL_BLACK;
        end else if (mode_nxt == mode_r) begin
          out_item_nxt.led_command = LED_RING;
          out_item_nxt.led_pattern = ring_pattern_r;
        end
      end
      MODE_SLEEPSTART: begin
        sleep_mark_nxt           = s1_item_r.now_seconds;
        steps_done_nxt           = '0;
        out_item_nxt.led_command = LED_FADE_START;
      end
      MODE_SLEEPDELAY: begin
        if (mode_nxt != mode_r) sleep_mark_nxt = s1_item_r.now_seconds;
      end
      default: begin
        if (sleep_el > SEC_W'(step_len_r) && mode_nxt == mode_r) begin
          sleep_mark_nxt           = s1_item_r.now_seconds;
          steps_done_nxt           = steps_done_r + 1'b1;
          out_item_nxt.led_command = LED_FADE_STEP;
        end
      end
    endcase

    out_item_nxt.mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      mode_r         <= MODE_INIT;
      last_sec_r     <= '0;
      last_sod_r     <= '0;
      snooze_began_r <= '0;
      sleep_mark_r   <= '0;
      steps_done_r   <= '0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (adv) begin
        out_valid_r    <= 1'b1;
        mode_r         <= mode_nxt;
        last_sec_r     <= last_sec_nxt;
        last_sod_r     <= last_sod_nxt;
        snooze_began_r <= snooze_began_nxt;
        sleep_mark_r   <= sleep_mark_nxt;
        steps_done_r   <= steps_done_nxt;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item_r  <= in_data;
    if (adv)                  out_item_r <= out_item_nxt;
  end

  // result mode always tracks the state register
  a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && out_item_r.mode == mode_r)
    else $error("result mode differs from state register");

  a_ok_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status_ok_pulse |-> out_item_r.mode == MODE_CONFIG)
    else $error("status pulse outside init exit");

  a_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.led_command != LED_RING |-> out_item_r.led_pattern == '0)
    else $error("pattern without ring command");

  a_sleep_seq: assert property (@(posedge clk) disable iff (!rst_n)
    adv && mode_r == MODE_SLEEPSTART |=> mode_r == MODE_SLEEPDELAY && steps_done_r == '0)
    else $error("sleep start did not enter delay");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(steps_done_r) <= 32'(FADE_STEPS) + 32'd1)
    else $error("fade step count overran");

endmodule
